### hdl/tvsg_pkg.sv
// Shared definitions for the three-voice sound generator: register map,
// envelope step codes, level table and derived widths.
// No dependencies.
package tvsg_pkg;

    localparam int VOICES = 3;

    localparam int MIX_W     = 18;
    localparam int LEVEL_MAX = 65535;
    localparam int SUM_RAW_W = $clog2(VOICES * LEVEL_MAX + 1);
    localparam int SUM_W     = (SUM_RAW_W > MIX_W) ? SUM_RAW_W : MIX_W;

    // beat command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // chip register map
    localparam logic [3:0] REG_TONE_LAST    = 4'd5;
    localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
    localparam logic [3:0] REG_MIXER        = 4'd7;
    localparam logic [3:0] REG_AMP_A        = 4'd8;
    localparam logic [3:0] REG_AMP_C        = 4'd10;
    localparam logic [3:0] REG_ENV_LO       = 4'd11;
    localparam logic [3:0] REG_ENV_HI       = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

    // envelope step per shape and phase
    typedef logic [1:0] t_env_act;
    localparam t_env_act ENV_FALL   = 2'd0;
    localparam t_env_act ENV_RISE   = 2'd1;
    localparam t_env_act ENV_HOLD0  = 2'd2;
    localparam t_env_act ENV_HOLD31 = 2'd3;

    function automatic t_env_act env_action(input logic [3:0] shape, input logic phase);
        t_env_act act;
        if (!phase) begin
            act = shape[2] ? ENV_RISE : ENV_FALL;
        end else begin
            case (shape)
                4'd8, 4'd14:  act = ENV_FALL;
                4'd10, 4'd12: act = ENV_RISE;
                4'd11, 4'd13: act = ENV_HOLD31;
                default:      act = ENV_HOLD0;
            endcase
        end
        return act;
    endfunction

    // level the envelope starts from when it enters a phase
    function automatic logic [4:0] env_start_level(input t_env_act act);
        return (act == ENV_FALL || act == ENV_HOLD31) ? 5'd31 : 5'd0;
    endfunction

    // logarithmic dac table, q0.16
    function automatic logic [15:0] dac_level(input logic [3:0] code);
        logic [15:0] lvl;
        case (code)
            4'd0:    lvl = 16'd0;
            4'd1:    lvl = 16'd655;
            4'd2:    lvl = 16'd947;
            4'd3:    lvl = 16'd1380;
            4'd4:    lvl = 16'd2012;
            4'd5:    lvl = 16'd2985;
            4'd6:    lvl = 16'd4227;
            4'd7:    lvl = 16'd7036;
            4'd8:    lvl = 16'd8296;
            4'd9:    lvl = 16'd13434;
            4'd10:   lvl = 16'd19150;
            4'd11:   lvl = 16'd24434;
            4'd12:   lvl = 16'd32278;
            4'd13:   lvl = 16'd41636;
            4'd14:   lvl = 16'd52794;
            default: lvl = 16'd65535;
        endcase
        return lvl;
    endfunction

endpackage

### hdl/three_voice_sound_generator.sv
// Three-voice sound generator: tone, noise and envelope generators, mixer
// and dac level sum, all in one pass. Depends on tvsg_pkg.
//
// Every input beat is a chip register write (i_cmd low) or one generator
// tick (i_cmd high). One beat is taken per clock. A write updates the
// registers and gives no output beat; a tick advances noise, envelope and
// tones and gives one output beat from the output register in the next
// cycle. The state update is a single pass of counter and compare
// logic, so the rate is one beat per cycle; input stall is raised only
// while the output register holds a beat that the sink is stalling.
module three_voice_sound_generator
    import tvsg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_cmd,
    input  logic [3:0]       i_reg_addr,
    input  logic [7:0]       i_write_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [MIX_W-1:0] o_mixed_level,
    output logic [4:0]       o_level_index_a,
    output logic [4:0]       o_level_index_b,
    output logic [4:0]       o_level_index_c
);

    logic [11:0] r_tone_period [VOICES];
    logic [11:0] n_tone_period [VOICES];
    logic [11:0] r_tone_count  [VOICES];
    logic [11:0] n_tone_count  [VOICES];
    logic        r_tone_bit    [VOICES];
    logic        n_tone_bit    [VOICES];
    logic        r_tone_dis    [VOICES];
    logic        n_tone_dis    [VOICES];
    logic        r_noise_dis   [VOICES];
    logic        n_noise_dis   [VOICES];
    logic        r_env_sel     [VOICES];
    logic        n_env_sel     [VOICES];
    logic [3:0]  r_fixed_vol   [VOICES];
    logic [3:0]  n_fixed_vol   [VOICES];

    logic [4:0]  r_noise_rate, n_noise_rate;
    logic [5:0]  r_noise_count, n_noise_count;
    logic [16:0] r_noise_shift, n_noise_shift;
    logic [15:0] r_env_rate, n_env_rate;
    logic [15:0] r_env_count, n_env_count;
    logic [3:0]  r_env_shape, n_env_shape;
    logic        r_env_phase, n_env_phase;
    logic [4:0]  r_env_level, n_env_level;

    logic             r_out_valid;
    logic [MIX_W-1:0] r_mixed;
    logic [MIX_W-1:0] n_mixed;
    logic [4:0]       r_index [3];
    logic [4:0]       n_index [3];
    logic [4:0]       voice_idx [VOICES];

    logic             in_accept;
    logic             tick;
    logic             wr;
    logic [4:0]       noise_per;
    logic [11:0]      tone_inc;
    logic [4:0]       amp;
    logic             gate;
    t_env_act         act;
    t_env_act         act_next;
    logic [SUM_W-1:0] sum;

    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign tick      = in_accept && (i_cmd == CMD_TICK);
    assign wr        = in_accept && (i_cmd == CMD_WRITE);

    always_comb begin
        n_tone_period = r_tone_period;
        n_tone_count  = r_tone_count;
        n_tone_bit    = r_tone_bit;
        n_tone_dis    = r_tone_dis;
        n_noise_dis   = r_noise_dis;
        n_env_sel     = r_env_sel;
        n_fixed_vol   = r_fixed_vol;
        n_noise_rate  = r_noise_rate;
        n_noise_count = r_noise_count;
        n_noise_shift = r_noise_shift;
        n_env_rate    = r_env_rate;
        n_env_count   = r_env_count;
        n_env_shape   = r_env_shape;
        n_env_phase   = r_env_phase;
        n_env_level   = r_env_level;
        noise_per     = (r_noise_rate == 5'd0) ? 5'd1 : r_noise_rate;
        act           = env_action(r_env_shape, r_env_phase);
        act_next      = env_action(r_env_shape, !r_env_phase);
        tone_inc      = '0;
        amp           = '0;
        gate          = 1'b0;
        sum           = '0;

        if (wr) begin
            for (int v = 0; v < VOICES; v++) begin
                if (i_reg_addr <= REG_TONE_LAST && i_reg_addr[3:1] == 3'(v)) begin
                    if (i_reg_addr[0]) begin
                        n_tone_period[v] = {i_write_data[3:0], r_tone_period[v][7:0]};
                    end else begin
                        n_tone_period[v] = {r_tone_period[v][11:8], i_write_data};
                    end
                end
                if (i_reg_addr == REG_MIXER && v < 3) begin
                    n_tone_dis[v]  = i_write_data[v];
                    n_noise_dis[v] = i_write_data[v+3];
                end
                if (i_reg_addr inside {[REG_AMP_A:REG_AMP_C]}
                        && i_reg_addr == REG_AMP_A + 4'(v)) begin
                    n_env_sel[v]   = i_write_data[4];
                    n_fixed_vol[v] = i_write_data[3:0];
                end
            end
            case (i_reg_addr)
                REG_NOISE_PERIOD: n_noise_rate = i_write_data[4:0];
                REG_ENV_LO:       n_env_rate   = {r_env_rate[15:8], i_write_data};
                REG_ENV_HI:       n_env_rate   = {i_write_data, r_env_rate[7:0]};
                REG_ENV_SHAPE: begin
                    n_env_shape = i_write_data[3:0];
                    n_env_count = '0;
                    n_env_phase = 1'b0;
                    n_env_level = i_write_data[2] ? 5'd0 : 5'd31;
                end
                default: ;
            endcase
        end

        if (tick) begin
            // noise: shift every 2 * period ticks
            n_noise_count = r_noise_count + 6'd1;
            if (n_noise_count >= {noise_per, 1'b0}) begin
                n_noise_count = '0;
                n_noise_shift = {r_noise_shift[0] ^ r_noise_shift[3], r_noise_shift[16:1]};
            end

            n_env_count = r_env_count + 16'd1;
            if (n_env_count >= r_env_rate) begin
                n_env_count = '0;
                if (act == ENV_RISE) begin
                    if (r_env_level == 5'd31) begin
                        n_env_phase = !r_env_phase;
                        n_env_level = env_start_level(act_next);
                    end else begin
                        n_env_level = r_env_level + 5'd1;
                    end
                end else if (act == ENV_FALL) begin
                    if (r_env_level == 5'd0) begin
                        n_env_phase = !r_env_phase;
                        n_env_level = env_start_level(act_next);
                    end else begin
                        n_env_level = r_env_level - 5'd1;
                    end
                end
            end

            for (int v = 0; v < VOICES; v++) begin
                tone_inc = r_tone_count[v] + 12'd1;
                if (tone_inc >= r_tone_period[v]) begin
                    n_tone_count[v] = '0;
                    n_tone_bit[v]   = !r_tone_bit[v];
                end else begin
                    n_tone_count[v] = tone_inc;
                end
            end
        end

        // mixer on the updated state
        for (int v = 0; v < VOICES; v++) begin
            gate = (n_tone_bit[v] | r_tone_dis[v]) & (n_noise_shift[0] | r_noise_dis[v]);
            amp  = r_env_sel[v] ? n_env_level : {r_fixed_vol[v], 1'b1};
            voice_idx[v] = gate ? amp : 5'd0;
            sum = sum + SUM_W'(dac_level(voice_idx[v][4:1]));
        end
        n_mixed = (sum > SUM_W'({MIX_W{1'b1}})) ? {MIX_W{1'b1}} : sum[MIX_W-1:0];
    end

    for (genvar g = 0; g < 3; g++) begin : g_index
        if (g < VOICES) begin : g_used
            assign n_index[g] = voice_idx[g];
        end else begin : g_absent
            assign n_index[g] = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_tone_period[v] <= 12'd1;
                r_tone_count[v]  <= '0;
                r_tone_bit[v]    <= 1'b0;
                r_tone_dis[v]    <= 1'b0;
                r_noise_dis[v]   <= (v == 0);
                r_env_sel[v]     <= 1'b0;
                r_fixed_vol[v]   <= (v == 0) ? 4'd15 : 4'd0;
            end
            r_noise_rate  <= '0;
            r_noise_count <= '0;
            r_noise_shift <= 17'd1;
            r_env_rate    <= 16'd1;
            r_env_count   <= '0;
            r_env_shape   <= '0;
            r_env_phase   <= 1'b0;
            r_env_level   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_tone_period <= n_tone_period;
            r_tone_count  <= n_tone_count;
            r_tone_bit    <= n_tone_bit;
            r_tone_dis    <= n_tone_dis;
            r_noise_dis   <= n_noise_dis;
            r_env_sel     <= n_env_sel;
            r_fixed_vol   <= n_fixed_vol;
            r_noise_rate  <= n_noise_rate;
            r_noise_count <= n_noise_count;
            r_noise_shift <= n_noise_shift;
            r_env_rate    <= n_env_rate;
            r_env_count   <= n_env_count;
            r_env_shape   <= n_env_shape;
            r_env_phase   <= n_env_phase;
            r_env_level   <= n_env_level;
            if (tick) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload, loaded only with a tick result
    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_mixed <= n_mixed;
            r_index <= n_index;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_mixed_level   = r_mixed;
    assign o_level_index_a = r_index[0];
    assign o_level_index_b = r_index[1];
    assign o_level_index_c = r_index[2];

`ifndef ASSERT_OFF
    a_noise_alive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_shift != 17'd0)
        else $error("noise shift register locked at zero");

    a_beat_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_accept && i_cmd == CMD_TICK))
        else $error("output beat without an accepted tick");

    a_shape_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr && i_reg_addr == REG_ENV_SHAPE |=> r_env_count == 16'd0 && !r_env_phase)
        else $error("shape write did not restart the envelope");

    a_silent_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        VOICES == 3 && o_valid && o_level_index_a == 5'd0 && o_level_index_b == 5'd0
        && o_level_index_c == 5'd0 |-> o_mixed_level == '0)
        else $error("mixed level nonzero with all voices silent");
`endif

endmodule
